// File: hw/rtl/vss_pkg.sv
// Shared types, constants and the digit font of the voltmeter display scanner.
`timescale 1ns / 1ps

package vss_pkg;

    localparam int READING_W = 34;
    localparam int GAIN_W    = 20;
    localparam int OFFSET_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SEG_W     = 8;
    localparam int DIG_N     = 4;
    localparam int IDX_W     = 2;
    localparam int HUND_W    = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 20'd329560;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -32'sd166039716;

    localparam logic [READING_W-1:0] OVER_Q16 = 34'd655360000;

    localparam logic [IDX_W-1:0] DIG_HUNDREDTHS = 2'd0;
    localparam logic [IDX_W-1:0] DIG_TENTHS     = 2'd1;
    localparam logic [IDX_W-1:0] DIG_ONES       = 2'd2;
    localparam logic [IDX_W-1:0] DIG_TENS       = 2'd3;

    localparam logic [SEG_W-1:0] SEG_DP = 8'h80;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [DIG_N-1:0] digit_enable;
        logic             overrange;
    } t_tick_res;

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0: code = 8'h3F;
            4'd1: code = 8'h06;
            4'd2: code = 8'h5B;
            4'd3: code = 8'h4F;
            4'd4: code = 8'h66;
            4'd5: code = 8'h6D;
            4'd6: code = 8'h7D;
            4'd7: code = 8'h07;
            4'd8: code = 8'h7F;
            4'd9: code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/vss_scale.sv
// Affine scaling of an ADC code to a saturated Q16 reading.
`timescale 1ns / 1ps

module vss_scale #(
    parameter int ADC_BITS = 10
) (
    input  logic [ADC_BITS-1:0]                 i_adc_code,
    input  logic [vss_pkg::GAIN_W-1:0]          i_gain,
    input  logic signed [vss_pkg::OFFSET_W-1:0] i_offset,
    output logic signed [vss_pkg::READING_W-1:0] o_reading
);
    import vss_pkg::*;

    localparam int PROD_W = ADC_BITS + GAIN_W;
    localparam int BASE_W = (PROD_W + 1 > OFFSET_W) ? PROD_W + 1 : OFFSET_W;
    localparam int SUM_W  = ((BASE_W > READING_W) ? BASE_W : READING_W) + 1;

    logic [PROD_W-1:0]       prod;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-READING_W:0] top_bits;

    assign prod     = PROD_W'(i_adc_code) * PROD_W'(i_gain);
    assign sum      = $signed({{(SUM_W - PROD_W){1'b0}}, prod})
                      + $signed({{(SUM_W - OFFSET_W){i_offset[OFFSET_W-1]}}, i_offset});
    assign top_bits = sum[SUM_W-1:READING_W-1];

    always_comb begin
        if ((top_bits == '0) || (top_bits == '1)) begin
            o_reading = sum[READING_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_reading = {1'b1, {(READING_W-1){1'b0}}};
        end else begin
            o_reading = {1'b0, {(READING_W-1){1'b1}}};
        end
    end

endmodule

// File: hw/rtl/vss_digit.sv
// Magnitude check, BCD split and segment coding of one display digit.
`timescale 1ns / 1ps

module vss_digit (
    input  logic signed [vss_pkg::READING_W-1:0] i_reading,
    input  logic [vss_pkg::IDX_W-1:0]            i_scan_index,
    input  logic [vss_pkg::SEG_W-1:0]            i_segment_latch,
    output vss_pkg::t_tick_res                   o_res
);
    import vss_pkg::*;

    logic                 neg;
    logic [READING_W-1:0] mag;
    logic [HUND_W-1:0]    h;
    logic [26:0]          p1;
    logic [26:0]          p2;
    logic [27:0]          p3;
    logic [HUND_W-1:0]    q1;
    logic [HUND_W-1:0]    q2;
    logic [HUND_W-1:0]    q3;
    logic [HUND_W-1:0]    d0;
    logic [HUND_W-1:0]    d1;
    logic [HUND_W-1:0]    d2;
    logic [3:0]           digit;
    logic [SEG_W-1:0]     seg;

    assign neg = i_reading[READING_W-1];
    assign mag = neg ? (~i_reading + 1'b1) : i_reading;
    assign h   = mag[16 +: HUND_W];

    // Constant reciprocals give exact quotients for every value below 10000.
    assign p1 = 27'(h) * 27'd6554;
    assign p2 = 27'(h) * 27'd5243;
    assign p3 = 28'(h) * 28'd8389;
    assign q1 = HUND_W'(p1 >> 16);
    assign q2 = HUND_W'(p2 >> 19);
    assign q3 = HUND_W'(p3 >> 23);
    assign d0 = h  - HUND_W'(q1 * 4'd10);
    assign d1 = q1 - HUND_W'(q2 * 4'd10);
    assign d2 = q2 - HUND_W'(q3 * 4'd10);

    always_comb begin
        case (i_scan_index)
            DIG_HUNDREDTHS: digit = d0[3:0];
            DIG_TENTHS:     digit = d1[3:0];
            DIG_ONES:       digit = d2[3:0];
            DIG_TENS:       digit = q3[3:0];
            default:        digit = d0[3:0];
        endcase
        seg = seg_font(digit);
        if ((i_scan_index == DIG_ONES) || ((i_scan_index == DIG_HUNDREDTHS) && neg)) begin
            seg = seg | SEG_DP;
        end
        if (mag >= OVER_Q16) begin
            o_res.segments     = i_segment_latch;
            o_res.digit_enable = '1;
            o_res.overrange    = 1'b1;
        end else begin
            o_res.segments     = seg;
            o_res.digit_enable = ~(DIG_N'(1) << i_scan_index);
            o_res.overrange    = 1'b0;
        end
    end

endmodule

// File: hw/rtl/voltmeter_seven_segment_scan_unit.sv
// Top level of the voltmeter reading scaler and seven-segment scan driver.
`timescale 1ns / 1ps

// Each item is held in the input register, where a sample item is
// scaled (one multiply, add and saturate) into the reading register and a tick
// item is turned into one digit's segment code that moves to the output
// register. An item can be accepted in every cycle; a sample item never
// stalls in the input register, and a tick item stalls there only while the
// output register is full and not being taken, which also holds off the next
// item. A sample item produces no result, a tick item exactly one.
// Configuration writes take effect at the next clock edge.
module voltmeter_seven_segment_scan_unit #(
    parameter int ADC_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vss_pkg::OFFSET_W-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_mode,
    input  logic [ADC_BITS-1:0]                i_adc_code,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [vss_pkg::SEG_W-1:0]          o_segments,
    output logic [vss_pkg::DIG_N-1:0]          o_digit_enable,
    output logic                               o_overrange
);
    import vss_pkg::*;

    logic [GAIN_W-1:0]          r_gain;
    logic signed [OFFSET_W-1:0] r_offset;
    logic                       r_in_valid;
    logic                       r_mode;
    logic [ADC_BITS-1:0]        r_adc_code;
    logic signed [READING_W-1:0] r_reading;
    logic [IDX_W-1:0]           r_scan_index;
    logic [SEG_W-1:0]           r_segment_latch;
    logic                       r_out_valid;
    t_tick_res                  r_out;

    logic signed [READING_W-1:0] n_reading;
    t_tick_res                   n_out;
    logic                        out_free;
    logic                        advance;

    vss_scale #(
        .ADC_BITS (ADC_BITS)
    ) u_scale (
        .i_adc_code (r_adc_code),
        .i_gain     (r_gain),
        .i_offset   (r_offset),
        .o_reading  (n_reading)
    );

    vss_digit u_digit (
        .i_reading       (r_reading),
        .i_scan_index    (r_scan_index),
        .i_segment_latch (r_segment_latch),
        .o_res           (n_out)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_mode || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain          <= GAIN_RESET;
            r_offset        <= OFFSET_RESET;
            r_in_valid      <= 1'b0;
            r_reading       <= '0;
            r_scan_index    <= '0;
            r_segment_latch <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_OFFSET: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance && !r_mode) begin
                r_reading <= n_reading;
            end
            if (advance && r_mode && !n_out.overrange) begin
                r_scan_index    <= r_scan_index + 1'b1;
                r_segment_latch <= n_out.segments;
            end
            if (advance && r_mode) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_mode     <= i_mode;
            r_adc_code <= i_adc_code;
        end
        if (advance && r_mode) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_segments     = r_out.segments;
    assign o_digit_enable = r_out.digit_enable;
    assign o_overrange    = r_out.overrange;

endmodule

// File: tb/vss_tb_pkg.sv
// Item kinds and spare register indexes shared by the scan unit testbench.
`timescale 1ns / 1ps

package vss_tb_pkg;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_TICK   = 1'b1
    } t_item_mode;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

endpackage

// File: tb/vss_scan_checker.sv
// Checker that predicts and compares every display tick result of the scan unit.
`timescale 1ns / 1ps

module vss_scan_checker #(
    parameter int ADC_W = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vss_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vss_pkg::OFFSET_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_mode,
    input  logic [ADC_W-1:0]              i_adc_code,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [vss_pkg::SEG_W-1:0]     i_segments,
    input  logic [vss_pkg::DIG_N-1:0]     i_digit_enable,
    input  logic                          i_overrange,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_samples,
    output int                            o_ticks,
    output int                            o_overranges
);
    import vss_pkg::*;
    import vss_tb_pkg::*;

    localparam longint READING_TOP    = 64'sd8589934591;
    localparam longint READING_BOTTOM = -64'sd8589934592;
    localparam logic [79:0] GLYPHS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                      8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

    logic [GAIN_W-1:0]              gain_q;
    logic signed [OFFSET_W-1:0]     offset_q;
    logic signed [READING_W-1:0]    reading_q;
    logic [IDX_W-1:0]               scan_q;
    logic [SEG_W-1:0]               latch_q;
    t_tick_res                      expected_digits[$];
    int                             mismatches = 0;
    int                             samples = 0;
    int                             ticks = 0;
    int                             overranges = 0;

    function automatic logic signed [READING_W-1:0] scale_adc(
        input logic [ADC_W-1:0]          code,
        input logic [GAIN_W-1:0]         g,
        input logic signed [OFFSET_W-1:0] off
    );
        longint c;
        longint g64;
        longint o64;
        longint sum;
        c   = code;
        g64 = g;
        o64 = off;
        sum = c * g64 + o64;
        if (sum > READING_TOP) begin
            sum = READING_TOP;
        end
        if (sum < READING_BOTTOM) begin
            sum = READING_BOTTOM;
        end
        return sum[READING_W-1:0];
    endfunction

    task automatic predict_tick();
        longint      r;
        longint      mag;
        logic        neg;
        int unsigned h;
        logic [3:0]  digit;
        t_tick_res   res;
        r   = reading_q;
        neg = (r < 0);
        mag = neg ? -r : r;
        if (mag >= longint'(OVER_Q16)) begin
            res.segments     = latch_q;
            res.digit_enable = '1;
            res.overrange    = 1'b1;
            overranges++;
        end else begin
            h = 32'(mag >> 16);
            case (scan_q)
                DIG_HUNDREDTHS: digit = 4'(h % 10);
                DIG_TENTHS:     digit = 4'((h / 10) % 10);
                DIG_ONES:       digit = 4'((h / 100) % 10);
                default:        digit = 4'((h / 1000) % 10);
            endcase
            res.segments = GLYPHS[digit*8 +: 8];
            if ((scan_q == DIG_HUNDREDTHS && neg) || scan_q == DIG_ONES) begin
                res.segments = res.segments | SEG_DP;
            end
            res.digit_enable = ~(4'b0001 << scan_q);
            res.overrange    = 1'b0;
            latch_q = res.segments;
            scan_q  = scan_q + 1'b1;
        end
        expected_digits.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_tick_res want;
        if (!i_rst_n) begin
            gain_q    = GAIN_RESET;
            offset_q  = OFFSET_RESET;
            reading_q = '0;
            scan_q    = '0;
            latch_q   = '0;
            expected_digits.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN:   gain_q = i_cfg_data[GAIN_W-1:0];
                    CFG_OFFSET: offset_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_digits.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected item seg=%02h en=%h ovr=%b", $time,
                             i_segments, i_digit_enable, i_overrange);
                end else begin
                    want = expected_digits.pop_front();
                    if (i_segments !== want.segments) begin
                        mismatches++;
                        $display("%0t: segments expected %02h, got %02h", $time,
                                 want.segments, i_segments);
                    end
                    if (i_digit_enable !== want.digit_enable) begin
                        mismatches++;
                        $display("%0t: digit_enable expected %h, got %h", $time,
                                 want.digit_enable, i_digit_enable);
                    end
                    if (i_overrange !== want.overrange) begin
                        mismatches++;
                        $display("%0t: overrange expected %b, got %b", $time,
                                 want.overrange, i_overrange);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == MODE_SAMPLE) begin
                    reading_q = scale_adc(i_adc_code, gain_q, offset_q);
                    samples++;
                end else begin
                    predict_tick();
                    ticks++;
                end
            end
        end
        o_outstanding <= expected_digits.size();
        o_mismatches  <= mismatches;
        o_samples     <= samples;
        o_ticks       <= ticks;
        o_overranges  <= overranges;
    end

endmodule

// File: tb/tb_top.sv
// Stimulus, handshake pacing and verdict for the voltmeter scan unit testbench.
`timescale 1ns / 1ps

module tb_top;
    import vss_pkg::*;
    import vss_tb_pkg::*;

    localparam int ADC_W = 10;
    localparam int RANDOM_ITEMS = 1250;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_GAIN;
    logic [OFFSET_W-1:0]  i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_SAMPLE;
    logic [ADC_W-1:0]     i_adc_code = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SEG_W-1:0]     o_segments;
    logic [DIG_N-1:0]     o_digit_enable;
    logic                 o_overrange;

    int mismatches;
    int outstanding;
    int samples;
    int ticks;
    int overranges;
    int settings = 0;
    bit quiet_phase = 1'b0;

    voltmeter_seven_segment_scan_unit #(
        .ADC_BITS(ADC_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_adc_code     (i_adc_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_segments     (o_segments),
        .o_digit_enable (o_digit_enable),
        .o_overrange    (o_overrange)
    );

    vss_scan_checker #(
        .ADC_W(ADC_W)
    ) scan_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_adc_code     (i_adc_code),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_segments     (o_segments),
        .i_digit_enable (o_digit_enable),
        .i_overrange    (o_overrange),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_samples      (samples),
        .o_ticks        (ticks),
        .o_overranges   (overranges)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Timed out with %0d results still expected.", outstanding);
        $display("FAIL voltmeter_seven_segment_scan_unit");
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input t_item_mode mode, input logic [ADC_W-1:0] code);
        int unsigned gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_adc_code <= code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(MODE_TICK, ADC_W'($urandom_range(0, 1023)));
    endtask

    // A sample item leaves no result behind, so settle also waits out its last step after the results drain.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input logic [GAIN_W-1:0] gain, input logic [OFFSET_W-1:0] offset);
        logic [31:0] junk;
        junk = $urandom;
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GAIN;
        i_cfg_data  <= {junk[31:GAIN_W], gain};
        @(posedge i_clk);
        i_cfg_index <= CFG_OFFSET;
        i_cfg_data  <= offset;
        @(posedge i_clk);
        i_cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
        i_cfg_data  <= $urandom;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings++;
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned len;
        int unsigned wait_cycles;
        logic [GAIN_W-1:0] g;
        longint span;
        longint centered;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_ticks(1);
        send_item(MODE_SAMPLE, 10'd0);
        send_ticks(4);
        send_item(MODE_SAMPLE, 10'd1023);
        send_ticks(4);
        send_item(MODE_SAMPLE, 10'h2AA);
        send_ticks(1);
        send_item(MODE_SAMPLE, 10'h155);
        send_ticks(1);

        // A tiny negative reading still lights the sign point on the hundredths digit.
        configure('0, -32'sd1);
        send_item(MODE_SAMPLE, 10'd1023);
        send_ticks(4);
        configure('0, 32'sd655359999);
        send_item(MODE_SAMPLE, 10'd0);
        send_ticks(2);
        configure('0, 32'sd655360000);
        send_item(MODE_SAMPLE, 10'd512);
        send_ticks(2);
        configure('1, 32'h8000_0000);
        send_item(MODE_SAMPLE, 10'd1023);
        send_ticks(1);
        configure('1, 32'h7FFF_FFFF);
        send_item(MODE_SAMPLE, 10'd1023);
        send_ticks(1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet_phase <= ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
                0: configure(GAIN_RESET, OFFSET_RESET);
                1, 2: begin
                    g = GAIN_W'($urandom_range(0, 640000));
                    span = longint'(g) * 1023;
                    centered = longint'($urandom_range(0, 1310720000)) - 655360000 - span / 2;
                    configure(g, centered[31:0]);
                end
                3: configure(GAIN_W'($urandom), $urandom);
                default: begin
                    centered = longint'($urandom_range(0, 1310720000)) - 655360000;
                    configure('0, centered[31:0]);
                end
            endcase
            len = $urandom_range(60, 140);
            repeat (len) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_item(MODE_SAMPLE, ADC_W'($urandom_range(0, 1023)));
                end else begin
                    send_item(MODE_TICK, ADC_W'($urandom_range(0, 1023)));
                end
                sent++;
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);

        $display("Drove %0d samples and %0d display ticks (%0d overrange) under %0d settings.",
                 samples, ticks, overranges, settings);
        $display("%0d mismatches, %0d results never arrived.", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS voltmeter_seven_segment_scan_unit");
        end else begin
            $display("FAIL voltmeter_seven_segment_scan_unit");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vss_pkg.sv
hw/rtl/vss_scale.sv
hw/rtl/vss_digit.sv
hw/rtl/voltmeter_seven_segment_scan_unit.sv
tb/vss_tb_pkg.sv
tb/vss_scan_checker.sv
tb/tb_top.sv
